/* rtl/srma_pkg.sv */
// Shared types and constants for the sparse row merge add/sub block.
package srma_pkg;

   localparam int COL_W            = 16;
   localparam int VAL_W            = 32;
   localparam int POS_W            = 6;
   localparam int ROW_CAPACITY_DEF = 32;
   localparam int QUEUE_DEPTH      = 4;   // power of two

   // request codes on req_type
   localparam logic [1:0] REQ_LOAD_A = 2'd0;
   localparam logic [1:0] REQ_LOAD_B = 2'd1;
   localparam logic [1:0] REQ_MERGE  = 2'd2;

   typedef enum logic [1:0] {
      KIND_LOAD_A = 2'd0,
      KIND_LOAD_B = 2'd1,
      KIND_MERGE  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [COL_W-1:0]        column;
      logic signed [VAL_W-1:0] value;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_PRIME = 3'b010,
      ST_RUN   = 3'b100
   } merge_state_type;

endpackage

/* rtl/srma_front.sv */
// Front end: takes request words, decodes them and hands commands to the queue.
module srma_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_type,
   input  logic [srma_pkg::COL_W-1:0]    req_column,
   input  logic signed [srma_pkg::VAL_W-1:0] req_value,
   output logic                          push_valid,
   output srma_pkg::cmd_type             push_cmd,
   input  logic                          push_ready
);

   logic              valid_ff, valid_in;
   srma_pkg::cmd_type cmd_ff, cmd_in;
   logic              accept;
   logic              is_cmd;
   srma_pkg::kind_type kind;

   assign req_stall  = valid_ff && !push_ready;
   assign accept     = req_valid && !req_stall;
   assign push_valid = valid_ff;
   assign push_cmd   = cmd_ff;

   always_comb begin
      is_cmd = 1'b1;
      kind   = srma_pkg::KIND_LOAD_A;
      case (req_type)
         srma_pkg::REQ_LOAD_A: kind = srma_pkg::KIND_LOAD_A;
         srma_pkg::REQ_LOAD_B: kind = srma_pkg::KIND_LOAD_B;
         srma_pkg::REQ_MERGE:  kind = srma_pkg::KIND_MERGE;
         default:              is_cmd = 1'b0;   // unused code, dropped
      endcase
   end

   always_comb begin
      cmd_in   = cmd_ff;
      valid_in = valid_ff && !push_ready;
      if (accept) begin
         valid_in      = is_cmd;
         cmd_in.kind   = kind;
         cmd_in.column = req_column;
         cmd_in.value  = req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

endmodule

/* rtl/srma_queue.sv */
// Short command queue between the front end and the merge engine.
module srma_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  srma_pkg::cmd_type push_cmd,
   output logic              push_ready,
   output logic              pop_valid,
   output srma_pkg::cmd_type pop_cmd,
   input  logic              pop
);

   localparam int DEPTH = srma_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   srma_pkg::cmd_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/srma_back.sv */
// Back end: row storage, two-pointer merge engine and result register.
module srma_back #(
   parameter int ROW_CAPACITY = srma_pkg::ROW_CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   input  srma_pkg::cmd_type                 cmd,
   output logic                              cmd_pop,
   input  logic                              csr_wr_en,
   input  logic                              csr_wr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [srma_pkg::COL_W-1:0]        rsp_column_res,
   output logic signed [srma_pkg::VAL_W-1:0] rsp_value_res,
   output logic                              rsp_present,
   output logic [srma_pkg::POS_W-1:0]        rsp_position,
   output logic                              rsp_overflow,
   output logic                              rsp_saturated,
   output logic                              rsp_last
);

   localparam int COL_W = srma_pkg::COL_W;
   localparam int VAL_W = srma_pkg::VAL_W;
   localparam int POS_W = srma_pkg::POS_W;
   localparam int IDX_W = (ROW_CAPACITY > 1) ? $clog2(ROW_CAPACITY) : 1;
   localparam int CNT_W = $clog2(ROW_CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP = CNT_W'(ROW_CAPACITY);

   // row storage
   logic [COL_W-1:0] a_col_mem [ROW_CAPACITY];
   logic [VAL_W-1:0] a_val_mem [ROW_CAPACITY];
   logic [COL_W-1:0] b_col_mem [ROW_CAPACITY];
   logic [VAL_W-1:0] b_val_mem [ROW_CAPACITY];

   logic [COL_W-1:0] a_col_rd_ff, b_col_rd_ff;
   logic [VAL_W-1:0] a_val_rd_ff, b_val_rd_ff;
   logic             a_we, b_we;
   logic [IDX_W-1:0] a_raddr, b_raddr;

   srma_pkg::merge_state_type state_ff, state_in;
   logic [CNT_W-1:0] a_cnt_ff, a_cnt_in, b_cnt_ff, b_cnt_in;
   logic [CNT_W-1:0] ia_ff, ia_in, ib_ff, ib_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             drop_ff, drop_in;
   logic             sub_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]         column_ff, column_in;
   logic signed [VAL_W-1:0]  value_ff, value_in;
   logic                     present_ff, present_in;
   logic [POS_W-1:0]         position_ff, position_in;
   logic                     overflow_ff, overflow_in;
   logic                     saturated_ff, saturated_in;
   logic                     last_ff, last_in;

   logic                     out_free;
   logic                     a_left, b_left, take_a, take_b;
   logic signed [VAL_W:0]    op_a, op_b, sum;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign a_left   = ia_ff < a_cnt_ff;
   assign b_left   = ib_ff < b_cnt_ff;
   assign take_a   = !b_left || (a_left && (a_col_rd_ff < b_col_rd_ff));
   assign take_b   = !take_a && (!a_left || (a_col_rd_ff > b_col_rd_ff));
   assign op_a     = take_b ? '0 : {a_val_rd_ff[VAL_W-1], a_val_rd_ff};
   assign op_b     = take_a ? '0 : {b_val_rd_ff[VAL_W-1], b_val_rd_ff};
   assign sum      = sub_ff ? op_a - op_b : op_a + op_b;

   always_comb begin
      state_in     = state_ff;
      a_cnt_in     = a_cnt_ff;
      b_cnt_in     = b_cnt_ff;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      pos_in       = pos_ff;
      drop_in      = drop_ff;
      cmd_pop      = 1'b0;
      a_we         = 1'b0;
      b_we         = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      column_in    = column_ff;
      value_in     = value_ff;
      present_in   = present_ff;
      position_in  = position_ff;
      overflow_in  = overflow_ff;
      saturated_in = saturated_ff;
      last_in      = last_ff;

      case (state_ff)
         srma_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  srma_pkg::KIND_LOAD_A: begin
                     cmd_pop = 1'b1;
                     if (a_cnt_ff < CAP) begin
                        a_we     = 1'b1;
                        a_cnt_in = a_cnt_ff + 1'b1;
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  srma_pkg::KIND_LOAD_B: begin
                     cmd_pop = 1'b1;
                     if (b_cnt_ff < CAP) begin
                        b_we     = 1'b1;
                        b_cnt_in = b_cnt_ff + 1'b1;
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  srma_pkg::KIND_MERGE: begin
                     if (a_cnt_ff == '0 && b_cnt_ff == '0) begin
                        // empty row: a single not-present word
                        if (out_free) begin
                           cmd_pop      = 1'b1;
                           rsp_valid_in = 1'b1;
                           column_in    = '0;
                           value_in     = '0;
                           present_in   = 1'b0;
                           position_in  = '0;
                           overflow_in  = drop_ff;
                           saturated_in = 1'b0;
                           last_in      = 1'b1;
                           drop_in      = 1'b0;
                        end
                     end else begin
                        cmd_pop  = 1'b1;
                        pos_in   = '0;
                        state_in = srma_pkg::ST_PRIME;
                     end
                  end
                  default: cmd_pop = 1'b1;
               endcase
            end
         end
         srma_pkg::ST_PRIME: begin
            // read registers now hold entry 0 of each list
            state_in = srma_pkg::ST_RUN;
         end
         srma_pkg::ST_RUN: begin
            if (out_free) begin
               ia_in = take_b ? ia_ff : ia_ff + 1'b1;
               ib_in = take_a ? ib_ff : ib_ff + 1'b1;
               rsp_valid_in = 1'b1;
               column_in    = take_b ? b_col_rd_ff : a_col_rd_ff;
               present_in   = 1'b1;
               position_in  = pos_ff;
               overflow_in  = drop_ff;
               saturated_in = sum[VAL_W] != sum[VAL_W-1];
               if (sum[VAL_W] != sum[VAL_W-1]) begin
                  value_in = sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}}
                                        : {1'b0, {(VAL_W-1){1'b1}}};
               end else begin
                  value_in = sum[VAL_W-1:0];
               end
               last_in = (ia_in >= a_cnt_ff) && (ib_in >= b_cnt_ff);
               pos_in  = pos_ff + 1'b1;
               if (last_in) begin
                  state_in = srma_pkg::ST_IDLE;
                  ia_in    = '0;
                  ib_in    = '0;
                  a_cnt_in = '0;
                  b_cnt_in = '0;
                  drop_in  = 1'b0;
               end
            end
         end
         default: state_in = srma_pkg::ST_IDLE;
      endcase

      a_raddr = (ia_in < CAP) ? ia_in[IDX_W-1:0] : '0;
      b_raddr = (ib_in < CAP) ? ib_in[IDX_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srma_pkg::ST_IDLE;
         a_cnt_ff     <= '0;
         b_cnt_ff     <= '0;
         ia_ff        <= '0;
         ib_ff        <= '0;
         pos_ff       <= '0;
         drop_ff      <= 1'b0;
         sub_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_cnt_ff     <= a_cnt_in;
         b_cnt_ff     <= b_cnt_in;
         ia_ff        <= ia_in;
         ib_ff        <= ib_in;
         pos_ff       <= pos_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            sub_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      column_ff    <= column_in;
      value_ff     <= value_in;
      present_ff   <= present_in;
      position_ff  <= position_in;
      overflow_ff  <= overflow_in;
      saturated_ff <= saturated_in;
      last_ff      <= last_in;
   end

   // list memories: one write and one registered read per list
   always_ff @(posedge clock) begin
      if (a_we) begin
         a_col_mem[a_cnt_ff[IDX_W-1:0]] <= cmd.column;
         a_val_mem[a_cnt_ff[IDX_W-1:0]] <= cmd.value;
      end
      a_col_rd_ff <= a_col_mem[a_raddr];
      a_val_rd_ff <= a_val_mem[a_raddr];
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         b_col_mem[b_cnt_ff[IDX_W-1:0]] <= cmd.column;
         b_val_mem[b_cnt_ff[IDX_W-1:0]] <= cmd.value;
      end
      b_col_rd_ff <= b_col_mem[b_raddr];
      b_val_rd_ff <= b_val_mem[b_raddr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_column_res = column_ff;
   assign rsp_value_res  = value_ff;
   assign rsp_present    = present_ff;
   assign rsp_position   = position_ff;
   assign rsp_overflow   = overflow_ff;
   assign rsp_saturated  = saturated_ff;
   assign rsp_last       = last_ff;

endmodule

/* rtl/sparse_row_merge_add_sub_core.sv */
// Top level of the sparse row merge add/sub block.
//
// Usage: req_ words load one (column, value) entry of row A (req_type 0) or
// row B (req_type 1), or end the row (req_type 2); code 3 is taken and
// ignored. Ending the row merges both lists in column order and sends one
// rsp_ word per merged entry, A+B or A-B by csr_wr_data (subtract when 1),
// with Q16.16 saturation. An empty row gives one word with rsp_present 0.
// Loads past ROW_CAPACITY per list are dropped and reported as
// rsp_overflow on every word of that row.
// Timing: the front register and queue pass one word per cycle, so loads
// sustain one per cycle while no merge is running. Ending a row pops the
// end-of-row word in the idle state, primes the list read registers in
// the prime state, then the single merge unit emits one result per cycle
// while rsp_stall is low. An empty row answers from the idle state without
// priming. Loads behind an end-of-row word wait in the queue until that
// merge finishes.
// Reset clears counts, flags, queue and valids; subtract mode returns to add.
// When rsp_stall is high the result register holds and the merge pauses;
// the queue keeps taking words until it fills, then req_stall rises.
module sparse_row_merge_add_sub_core #(
   parameter int ROW_CAPACITY = srma_pkg::ROW_CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_type,
   input  logic [srma_pkg::COL_W-1:0]        req_column,
   input  logic signed [srma_pkg::VAL_W-1:0] req_value,
   input  logic                              csr_wr_en,
   input  logic                              csr_wr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [srma_pkg::COL_W-1:0]        rsp_column_res,
   output logic signed [srma_pkg::VAL_W-1:0] rsp_value_res,
   output logic                              rsp_present,
   output logic [srma_pkg::POS_W-1:0]        rsp_position,
   output logic                              rsp_overflow,
   output logic                              rsp_saturated,
   output logic                              rsp_last
);

   // front -> queue
   logic              push_valid, push_ready;
   srma_pkg::cmd_type push_cmd;
   // queue -> merge engine
   logic              pop_valid, pop;
   srma_pkg::cmd_type pop_cmd;

   srma_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_type   (req_type),
      .req_column (req_column),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   srma_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop        (pop)
   );

   srma_back #(
      .ROW_CAPACITY (ROW_CAPACITY)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (pop_valid),
      .cmd            (pop_cmd),
      .cmd_pop        (pop),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_column_res (rsp_column_res),
      .rsp_value_res  (rsp_value_res),
      .rsp_present    (rsp_present),
      .rsp_position   (rsp_position),
      .rsp_overflow   (rsp_overflow),
      .rsp_saturated  (rsp_saturated),
      .rsp_last       (rsp_last)
   );

endmodule
